FILE: hw/rtl/svn_pkg.sv
// ----------------------------------------------------------------------------
// svn_pkg
// Shared widths, state codes and helpers for the smooth vertex normal block.
// ----------------------------------------------------------------------------
package svn_pkg;

    localparam int CoordW     = 16;                  // input coordinate, Q8.8
    localparam int DiffW      = CoordW + 1;          // edge vector component
    localparam int MulW       = 22;                  // shared multiplier operand
    localparam int ProdW      = 2 * MulW;
    localparam int SumW       = 42;                  // running cross sum
    localparam int HalfW      = SumW / 2;            // split for squaring
    localparam int SqW        = 2 * SumW;            // sum of squares
    localparam int RootW      = SumW;                // integer square root
    localparam int RootCntW   = $clog2(RootW);
    localparam int QuotW      = 16;                  // Q1.14 result
    localparam int DivCntW    = $clog2(QuotW);
    localparam int MaxValence = 64;
    localparam int CntW       = $clog2(MaxValence + 1);
    localparam int UnitOne    = 16384;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CROSS = 7'b0000010,
        S_ZCHK  = 7'b0000100,
        S_SQR   = 7'b0001000,
        S_ROOT  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    // magnitude of a two's complement sum; the most negative value maps to 2^41
    function automatic logic [SumW-1:0] mag(input logic [SumW-1:0] x);
        logic [SumW-1:0] neg;
        neg = ~x + {{(SumW-1){1'b0}}, 1'b1};
        return x[SumW-1] ? neg : x;
    endfunction

endpackage

FILE: hw/rtl/svn_sqrt.sv
// ----------------------------------------------------------------------------
// svn_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module svn_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [svn_pkg::SqW-1:0]       i_rad,
    output logic                          o_done,
    output logic [svn_pkg::RootW-1:0]     o_root
);

    logic                          r_busy;
    logic                          r_done;
    logic [svn_pkg::RootCntW-1:0]  r_cnt;
    logic [svn_pkg::SqW-1:0]       r_rad;
    logic [svn_pkg::RootW+3:0]     r_rem;
    logic [svn_pkg::RootW-1:0]     r_root;

    logic [svn_pkg::RootW+3:0]     n_t;
    logic [svn_pkg::RootW+3:0]     n_trial;
    logic                          n_ge;

    always_comb begin
        n_t     = {r_rem[svn_pkg::RootW+1:0], r_rad[svn_pkg::SqW-1 -: 2]};
        n_trial = {2'b00, r_root, 2'b01};
        n_ge    = (n_t >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= {r_rad[svn_pkg::SqW-3:0], 2'b00};
                r_rem  <= n_ge ? (n_t - n_trial) : n_t;
                r_root <= {r_root[svn_pkg::RootW-2:0], n_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == svn_pkg::RootCntW'(svn_pkg::RootW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: hw/rtl/svn_div.sv
// ----------------------------------------------------------------------------
// svn_div
// Restoring divider: (num * 16384) / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [svn_pkg::SumW-1:0]      i_num,   // num <= den assumed
    input  logic [svn_pkg::SumW-1:0]      i_den,
    output logic                          o_done,
    output logic [svn_pkg::QuotW-1:0]     o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [svn_pkg::DivCntW-1:0]   r_cnt;
    logic [svn_pkg::SumW-1:0]      r_rem;
    logic [svn_pkg::SumW-1:0]      r_den;
    logic [svn_pkg::QuotW-1:0]     r_sh;
    logic [svn_pkg::QuotW-1:0]     r_q;

    logic [svn_pkg::SumW:0]        n_t;
    logic [svn_pkg::SumW:0]        n_diff;
    logic                          n_ge;

    always_comb begin
        n_t    = {r_rem, r_sh[svn_pkg::QuotW-1]};
        n_ge   = (n_t >= {1'b0, r_den});
        n_diff = n_t - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // num << 14 split: top bits seed the remainder, rest shift in
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {2'b00, i_num[svn_pkg::SumW-1:2]};
                r_sh   <= {i_num[1:0], {(svn_pkg::QuotW-2){1'b0}}};
                r_den  <= i_den;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[svn_pkg::SumW-1:0] : n_t[svn_pkg::SumW-1:0];
                r_q   <= {r_q[svn_pkg::QuotW-2:0], n_ge};
                r_sh  <= {r_sh[svn_pkg::QuotW-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == svn_pkg::DivCntW'(svn_pkg::QuotW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: hw/rtl/smooth_vertex_normal.sv
// ----------------------------------------------------------------------------
// smooth_vertex_normal
// Area-weighted vertex normal from a stream of face corners.
// ----------------------------------------------------------------------------
// Each word on the slave side is one face corner of a vertex. A valid corner
// (tuser high) adds cross(next - curr, prev - curr) into three 42-bit sums,
// using one shared 22x22 multiplier for its six products in turn. Past 64
// valid corners further valid ones are dropped and flagged. The corner with
// tlast closes the vertex: the sums are checked for zero, squared and summed
// through the same multiplier, the length is taken by a digit serial root and
// each component is scaled to Q1.14 by a bit serial divider. A zero sum skips
// straight to the result.
// The result sits in an output register, so the next vertex can start while
// it waits to be taken. s_axis_tready is high only while the sequencer idles.
// ----------------------------------------------------------------------------
module smooth_vertex_normal (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // curr_x, curr_y, curr_z, prev_x, prev_y, prev_z, next_x, next_y, next_z
    input  logic [143:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // face_valid
    input  logic         s_axis_tlast,   // last_of_vertex
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // normal_x, normal_y, normal_z
    output logic [1:0]   m_axis_tuser    // zero_length, too_many_faces
);

    localparam int CW = svn_pkg::CoordW;
    localparam int DW = svn_pkg::DiffW;
    localparam int MW = svn_pkg::MulW;
    localparam int SW = svn_pkg::SumW;
    localparam int HW = svn_pkg::HalfW;
    localparam int QW = svn_pkg::QuotW;

    svn_pkg::t_state               r_state;
    logic signed [DW-1:0]          r_ex, r_ey, r_ez, r_dx, r_dy, r_dz;
    logic                          r_last;
    logic [SW-1:0]                 r_sum_x, r_sum_y, r_sum_z;
    logic [svn_pkg::CntW-1:0]      r_cnt;
    logic                          r_ovf;
    logic                          r_zero;
    logic [2:0]                    r_step;
    logic [1:0]                    r_idx;
    logic                          r_go;
    logic [svn_pkg::SqW-1:0]       r_acc;
    logic [svn_pkg::RootW-1:0]     r_root;
    logic [QW-1:0]                 r_nx, r_ny, r_nz;
    logic                          r_out_valid;
    logic [47:0]                   r_out_data;
    logic [1:0]                    r_out_user;

    // shared multiplier operands and product
    logic signed [MW-1:0]          n_ma, n_mb;
    logic signed [svn_pkg::ProdW-1:0] n_prod;
    logic                          n_sub;
    logic [SW-1:0]                 n_msel;     // magnitude of selected sum
    logic [SW-1:0]                 n_csel;     // selected sum, signed bits
    logic [SW-1:0]                 n_add;

    logic                          w_in_acc;
    logic                          w_root_done, w_div_done;
    logic [svn_pkg::RootW-1:0]     w_root;
    logic [QW-1:0]                 w_quot;
    logic [QW-1:0]                 n_qc, n_qs;

    function automatic logic signed [DW-1:0] diff(input logic [CW-1:0] a,
                                                  input logic [CW-1:0] b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // component select by r_idx
    always_comb begin
        unique case (r_idx)
            2'd0:    n_csel = r_sum_x;
            2'd1:    n_csel = r_sum_y;
            default: n_csel = r_sum_z;
        endcase
        n_msel = svn_pkg::mag(n_csel);
    end

    // operand selection for cross terms and for squaring
    always_comb begin
        n_ma  = '0;
        n_mb  = '0;
        n_sub = 1'b0;
        if (r_state == svn_pkg::S_CROSS) begin
            unique case (r_step)
                3'd0: begin n_ma = MW'(r_dy); n_mb = MW'(r_ez); end
                3'd1: begin n_ma = MW'(r_dz); n_mb = MW'(r_ey); n_sub = 1'b1; end
                3'd2: begin n_ma = MW'(r_dz); n_mb = MW'(r_ex); end
                3'd3: begin n_ma = MW'(r_dx); n_mb = MW'(r_ez); n_sub = 1'b1; end
                3'd4: begin n_ma = MW'(r_dx); n_mb = MW'(r_ey); end
                default: begin n_ma = MW'(r_dy); n_mb = MW'(r_ex); n_sub = 1'b1; end
            endcase
        end else begin
            // m = a * 2^21 + b: a*a, a*b, b*b
            unique case (r_step)
                3'd0: begin
                    n_ma = $signed({1'b0, n_msel[SW-1:HW]});
                    n_mb = $signed({1'b0, n_msel[SW-1:HW]});
                end
                3'd1: begin
                    n_ma = $signed({1'b0, n_msel[SW-1:HW]});
                    n_mb = $signed({1'b0, n_msel[HW-1:0]});
                end
                default: begin
                    n_ma = $signed({1'b0, n_msel[HW-1:0]});
                    n_mb = $signed({1'b0, n_msel[HW-1:0]});
                end
            endcase
        end
        n_prod = n_ma * n_mb;
        n_add  = n_prod[SW-1:0];
    end

    // clamp and sign the quotient
    always_comb begin
        n_qc = (w_quot > QW'(svn_pkg::UnitOne)) ? QW'(svn_pkg::UnitOne) : w_quot;
        n_qs = n_csel[SW-1] ? (~n_qc + 1'b1) : n_qc;
    end

    svn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == svn_pkg::S_ROOT && r_go),
        .i_rad   (r_acc),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    svn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == svn_pkg::S_DIV && r_go),
        .i_num   (n_msel),
        .i_den   (r_root),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svn_pkg::S_IDLE;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_zero      <= 1'b0;
            r_step      <= '0;
            r_idx       <= '0;
            r_go        <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: load a new result or drop the one taken
            if (r_state == svn_pkg::S_OUT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                svn_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_ex   <= diff(s_axis_tdata[63:48],   s_axis_tdata[15:0]);
                        r_ey   <= diff(s_axis_tdata[79:64],   s_axis_tdata[31:16]);
                        r_ez   <= diff(s_axis_tdata[95:80],   s_axis_tdata[47:32]);
                        r_dx   <= diff(s_axis_tdata[111:96],  s_axis_tdata[15:0]);
                        r_dy   <= diff(s_axis_tdata[127:112], s_axis_tdata[31:16]);
                        r_dz   <= diff(s_axis_tdata[143:128], s_axis_tdata[47:32]);
                        r_last <= s_axis_tlast;
                        r_step <= '0;
                        if (s_axis_tuser && r_cnt < svn_pkg::CntW'(svn_pkg::MaxValence)) begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= svn_pkg::S_CROSS;
                        end else begin
                            if (s_axis_tuser) begin
                                r_ovf <= 1'b1;
                            end
                            if (s_axis_tlast) begin
                                r_state <= svn_pkg::S_ZCHK;
                            end
                        end
                    end
                end
                svn_pkg::S_CROSS: begin
                    unique case (r_step)
                        3'd0, 3'd1: r_sum_x <= n_sub ? r_sum_x - n_add : r_sum_x + n_add;
                        3'd2, 3'd3: r_sum_y <= n_sub ? r_sum_y - n_add : r_sum_y + n_add;
                        default:    r_sum_z <= n_sub ? r_sum_z - n_add : r_sum_z + n_add;
                    endcase
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd5) begin
                        r_step  <= '0;
                        r_state <= r_last ? svn_pkg::S_ZCHK : svn_pkg::S_IDLE;
                    end
                end
                svn_pkg::S_ZCHK: begin
                    r_step <= '0;
                    r_idx  <= '0;
                    r_acc  <= '0;
                    if (r_sum_x == '0 && r_sum_y == '0 && r_sum_z == '0) begin
                        r_nx    <= '0;
                        r_ny    <= '0;
                        r_nz    <= '0;
                        r_zero  <= 1'b1;
                        r_state <= svn_pkg::S_OUT;
                    end else begin
                        r_zero  <= 1'b0;
                        r_state <= svn_pkg::S_SQR;
                    end
                end
                svn_pkg::S_SQR: begin
                    unique case (r_step)
                        3'd0:    r_acc <= r_acc + {n_add, {SW{1'b0}}};
                        3'd1:    r_acc <= r_acc + {{(SW-HW-1){1'b0}}, n_add, {(HW+1){1'b0}}};
                        default: r_acc <= r_acc + {{SW{1'b0}}, n_add};
                    endcase
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd2) begin
                        r_step <= '0;
                        if (r_idx == 2'd2) begin
                            r_idx   <= '0;
                            r_go    <= 1'b1;
                            r_state <= svn_pkg::S_ROOT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                svn_pkg::S_ROOT: begin
                    r_go <= 1'b0;
                    if (w_root_done) begin
                        // a nonzero sum never gives a zero root
                        r_root  <= w_root;
                        r_idx   <= '0;
                        r_go    <= 1'b1;
                        r_state <= svn_pkg::S_DIV;
                    end
                end
                svn_pkg::S_DIV: begin
                    r_go <= 1'b0;
                    if (w_div_done) begin
                        unique case (r_idx)
                            2'd0:    r_nx <= n_qs;
                            2'd1:    r_ny <= n_qs;
                            default: r_nz <= n_qs;
                        endcase
                        if (r_idx == 2'd2) begin
                            r_state <= svn_pkg::S_OUT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_go  <= 1'b1;
                        end
                    end
                end
                svn_pkg::S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= {r_nz, r_ny, r_nx};
                        r_out_user  <= {r_ovf, r_zero};
                        r_sum_x     <= '0;
                        r_sum_y     <= '0;
                        r_sum_z     <= '0;
                        r_cnt       <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= svn_pkg::S_IDLE;
                    end
                end
                default: r_state <= svn_pkg::S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == svn_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
